### sv/binary_to_decimal_ascii_emitter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary to decimal ASCII emitter
// Short forms for clocked properties on clk with rst as the disable term.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_EMITTER_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_EMITTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTDA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/btda_pkg.sv
// ----------------------------------------------------------------------------
// btda_pkg
// Shared widths, constants and types of the binary to decimal ASCII emitter.
// ----------------------------------------------------------------------------
package btda_pkg;

  // Width of the binary input value.
  localparam int VALUE_BITS = 32;

  // Decimal digits needed for the widest value: floor(bits * log10(2)) + 1.
  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

  // Counter widths for the conversion bits and the remaining digits.
  localparam int BIT_CNT_W = $clog2(VALUE_BITS);
  localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

  // Shift-add-3 correction: a digit of five or more gets three added.
  localparam int DIGIT_ADJ_LIMIT = 5;
  localparam int DIGIT_ADJ       = 3;

  // ASCII code of the character '0'.
  localparam int ASCII_ZERO = 48;

  typedef logic [3:0] digit_t;

  // Operation applied to every cell of the digit chain at once.
  typedef enum logic [1:0] {
    CHAIN_HOLD,
    CHAIN_LOAD,
    CHAIN_CONVERT,
    CHAIN_SHIFT
  } chain_op_t;

endpackage

### sv/btda_in_if.sv
// ----------------------------------------------------------------------------
// btda_in_if
// Valid/ready channel that carries one binary value per beat.
// ----------------------------------------------------------------------------
interface btda_in_if;
  logic                             valid;
  logic                             ready;
  logic [btda_pkg::VALUE_BITS-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

### sv/btda_out_if.sv
// ----------------------------------------------------------------------------
// btda_out_if
// Valid/ready channel that carries one ASCII digit per beat.
// ----------------------------------------------------------------------------
interface btda_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] digit_char;
  logic       last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

### sv/btda_cell.sv
// ----------------------------------------------------------------------------
// btda_cell
// One BCD digit of the conversion chain: shift-add-3 step or digit shift.
// ----------------------------------------------------------------------------
module btda_cell (
  input  logic                clk,
  input  btda_pkg::chain_op_t op,
  input  logic                bit_in,
  input  btda_pkg::digit_t    digit_in,
  output logic                bit_out,
  output btda_pkg::digit_t    digit
);

  btda_pkg::digit_t adjusted;

  // Correct the digit before it doubles so that it stays a valid BCD digit.
  always_comb begin
    if (digit >= 4'(btda_pkg::DIGIT_ADJ_LIMIT)) begin
      adjusted = digit + 4'(btda_pkg::DIGIT_ADJ);
    end else begin
      adjusted = digit;
    end
  end

  // The top bit of the corrected digit carries into the next cell.
  assign bit_out = adjusted[3];

  // Digit register.
  always_ff @(posedge clk) begin
    unique case (op)
      btda_pkg::CHAIN_HOLD:    digit <= digit;
      btda_pkg::CHAIN_LOAD:    digit <= '0;
      btda_pkg::CHAIN_CONVERT: digit <= {adjusted[2:0], bit_in};
      btda_pkg::CHAIN_SHIFT:   digit <= digit_in;
      default:                 digit <= digit;
    endcase
  end

endmodule

### sv/btda_chain.sv
// ----------------------------------------------------------------------------
// btda_chain
// Binary shift register feeding a row of BCD digit cells.
// ----------------------------------------------------------------------------
module btda_chain (
  input  logic                            clk,
  input  btda_pkg::chain_op_t             op,
  input  logic [btda_pkg::VALUE_BITS-1:0] value,
  output btda_pkg::digit_t                top_digit
);

  logic [btda_pkg::VALUE_BITS-1:0] shreg;
  logic             carry  [btda_pkg::NUM_DIGITS];
  btda_pkg::digit_t digits [btda_pkg::NUM_DIGITS];

  // Binary value, shifted out most significant bit first while converting.
  always_ff @(posedge clk) begin
    unique case (op)
      btda_pkg::CHAIN_LOAD:    shreg <= value;
      btda_pkg::CHAIN_CONVERT: shreg <= {shreg[btda_pkg::VALUE_BITS-2:0], 1'b0};
      default:                 shreg <= shreg;
    endcase
  end

  // Cell zero is the least significant digit; the top cell is the next one out.
  for (genvar i = 0; i < btda_pkg::NUM_DIGITS; i++) begin : g_cell
    logic             bit_in;
    btda_pkg::digit_t digit_in;

    if (i == 0) begin : g_first
      assign bit_in   = shreg[btda_pkg::VALUE_BITS-1];
      assign digit_in = '0;
    end else begin : g_rest
      assign bit_in   = carry[i-1];
      assign digit_in = digits[i-1];
    end

    btda_cell u_cell (
      .clk      (clk),
      .op       (op),
      .bit_in   (bit_in),
      .digit_in (digit_in),
      .bit_out  (carry[i]),
      .digit    (digits[i])
    );
  end

  assign top_digit = digits[btda_pkg::NUM_DIGITS-1];

endmodule

### sv/binary_to_decimal_ascii_emitter.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_emitter
// Converts an unsigned binary value to its decimal digits as ASCII codes.
// ----------------------------------------------------------------------------
// One value is taken at a time. It shifts bit by bit into a row of BCD digit
// cells (shift-add-3), then leading zero digits are dropped one at a time and
// the remaining digits go out most significant first, one beat per cycle
// while the sink is ready, the last one marked by last_digit. Zero gives a
// single '0'. A new value is taken only after the last digit has gone out;
// the block keeps nothing between values.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_emitter (
  input  logic              clk,
  input  logic              rst,
  btda_in_if.sink           number,
  btda_out_if.source        text
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_EMIT
  } state_t;

  localparam logic [btda_pkg::DIG_CNT_W-1:0] DIG_ONE = btda_pkg::DIG_CNT_W'(1);

  state_t                          state;
  logic [btda_pkg::BIT_CNT_W-1:0]  bit_cnt;
  logic [btda_pkg::DIG_CNT_W-1:0]  remaining;
  btda_pkg::chain_op_t             op;
  btda_pkg::digit_t                top_digit;
  logic                            leading_zero;
  logic                            last;

  assign leading_zero = (top_digit == '0) && (remaining > DIG_ONE);
  assign last         = (remaining == DIG_ONE);

  // Operation for the cell row in this cycle.
  always_comb begin
    unique case (state)
      ST_IDLE:    op = number.valid ? btda_pkg::CHAIN_LOAD : btda_pkg::CHAIN_HOLD;
      ST_CONVERT: op = btda_pkg::CHAIN_CONVERT;
      ST_SKIP:    op = leading_zero ? btda_pkg::CHAIN_SHIFT : btda_pkg::CHAIN_HOLD;
      ST_EMIT:    op = (text.ready && !last) ? btda_pkg::CHAIN_SHIFT
                                             : btda_pkg::CHAIN_HOLD;
      default:    op = btda_pkg::CHAIN_HOLD;
    endcase
  end

  // Sequencer: load, convert, drop leading zeros, emit digits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bit_cnt   <= '0;
      remaining <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (number.valid) begin
            state   <= ST_CONVERT;
            bit_cnt <= '0;
          end
        end
        ST_CONVERT: begin
          bit_cnt <= bit_cnt + btda_pkg::BIT_CNT_W'(1);
          if (bit_cnt == btda_pkg::BIT_CNT_W'(btda_pkg::VALUE_BITS - 1)) begin
            state     <= ST_SKIP;
            remaining <= btda_pkg::DIG_CNT_W'(btda_pkg::NUM_DIGITS);
          end
        end
        ST_SKIP: begin
          if (leading_zero) begin
            remaining <= remaining - DIG_ONE;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (text.ready) begin
            if (last) begin
              state <= ST_IDLE;
            end else begin
              remaining <= remaining - DIG_ONE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  btda_chain u_chain (
    .clk       (clk),
    .op        (op),
    .value     (number.value),
    .top_digit (top_digit)
  );

  // Handshakes and output beat, taken straight from the top cell.
  assign number.ready    = (state == ST_IDLE);
  assign text.valid      = (state == ST_EMIT);
  assign text.digit_char = 6'(btda_pkg::ASCII_ZERO) + {2'b00, top_digit};
  assign text.last_digit = last;

endmodule

### sv/btda_checker.sv
// ----------------------------------------------------------------------------
// btda_checker
// Port-level checks of the binary to decimal ASCII emitter, bound to the top.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_emitter_macros.svh"

module btda_checker (
  input logic       clk,
  input logic       rst,
  input logic       number_valid,
  input logic       number_ready,
  input logic       text_valid,
  input logic       text_ready,
  input logic [5:0] digit_char,
  input logic       last_digit
);

  // A stalled digit beat keeps its payload.
  `BTDA_ASSERT_NEXT(a_hold_stalled, text_valid && !text_ready, text_valid && $stable(digit_char) && $stable(last_digit), "stalled digit beat changed")

  // Every digit is an ASCII code from '0' to '9'.
  `BTDA_ASSERT_SAME(a_digit_range, text_valid, digit_char >= 6'd48 && digit_char <= 6'd57, "digit code out of range")

  // No new value is taken while digits are still going out.
  `BTDA_ASSERT_SAME(a_one_value, text_valid, !number_ready, "input ready while emitting")

  // Conversion takes time: no digit right after a value is taken.
  `BTDA_ASSERT_NEXT(a_convert_gap, number_valid && number_ready, !text_valid, "digit right after input beat")

  // The last digit frees the block for the next value.
  `BTDA_ASSERT_NEXT(a_last_frees, text_valid && text_ready && last_digit, number_ready && !text_valid, "not idle after last digit")

endmodule

bind binary_to_decimal_ascii_emitter btda_checker u_btda_checker (
  .clk          (clk),
  .rst          (rst),
  .number_valid (number.valid),
  .number_ready (number.ready),
  .text_valid   (text.valid),
  .text_ready   (text.ready),
  .digit_char   (text.digit_char),
  .last_digit   (text.last_digit)
);

### bench/binary_to_decimal_ascii_emitter_tb.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_emitter_tb
// Drives binary values into the emitter and checks every ASCII digit beat.
// ----------------------------------------------------------------------------
// A queue of pending values feeds a clocked driver on the number channel. A
// clocked monitor turns each accepted value into its expected decimal digits
// and compares every beat on the text channel with the oldest one, digit code
// and last mark alike. The run starts with edge values (zero, powers of ten,
// the largest value), then random values across all digit counts, under three
// idling mixes on both sides. One long receiver stall holds up the block while
// the driver keeps offering values, and the driver pauses between phases until
// all digits are back.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module binary_to_decimal_ascii_emitter_tb;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 10;
  localparam int DEC_BASE     = 10;
  localparam int MAX_DIGITS   = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 60;

  // One expected beat on the text channel.
  typedef struct packed {
    logic [5:0] digit_char;
    logic       last_digit;
  } digit_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  btda_in_if  number_bus ();
  btda_out_if text_bus ();

  logic [btda_pkg::VALUE_BITS-1:0] pending_values[$];
  digit_beat_t                     expected_digits[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_armed    = 1'b0;
  bit  receiver_held = 1'b0;
  int  mismatch_count = 0;

  binary_to_decimal_ascii_emitter u_top (
    .clk    (clk),
    .rst    (rst),
    .number (number_bus),
    .text   (text_bus)
  );

  // Clock generation.
  always #CLK_HALF clk = ~clk;

  // Prints one failure line and counts it.
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Appends the decimal digits of one value, most significant first.
  function automatic void push_decimal_digits(input logic [btda_pkg::VALUE_BITS-1:0] v);
    logic [3:0]      digs[MAX_DIGITS];
    logic [63:0]     rest;
    int              n;
    digit_beat_t     beat;
    rest = 64'(v);
    n = 0;
    do begin
      digs[n] = 4'(rest % DEC_BASE);
      rest = rest / DEC_BASE;
      n++;
    end while (rest != 0 && n < MAX_DIGITS);
    for (int k = 0; k < n; k++) begin
      beat.digit_char = 6'(digs[n - 1 - k] + btda_pkg::ASCII_ZERO);
      beat.last_digit = (k == n - 1);
      expected_digits.push_back(beat);
    end
  endfunction

  // Random value: half full-width, half spread evenly over digit counts.
  function automatic logic [btda_pkg::VALUE_BITS-1:0] random_value();
    int              ndig;
    longint unsigned scale;
    longint unsigned lo;
    longint unsigned hi;
    if ($urandom_range(1) == 0)
      return $urandom;
    ndig = $urandom_range(10, 1);
    scale = 1;
    repeat (ndig - 1) scale = scale * DEC_BASE;
    lo = (ndig == 1) ? 0 : scale;
    hi = scale * DEC_BASE - 1;
    if (hi > 64'hFFFF_FFFF)
      hi = 64'hFFFF_FFFF;
    return $urandom_range(hi[31:0], lo[31:0]);
  endfunction

  task automatic queue_random(input int count);
    repeat (count) pending_values.push_back(random_value());
  endtask

  // Waits until every value is taken and every digit has come back.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_values.size() != 0 || number_bus.valid ||
               expected_digits.size() != 0);
  endtask

  // Driver: offers the next pending value once the current beat is taken.
  always @(posedge clk) begin
    if (rst) begin
      number_bus.valid <= 1'b0;
      number_bus.value <= '0;
    end else if (!number_bus.valid || number_bus.ready) begin
      if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        number_bus.valid <= 1'b1;
        number_bus.value <= pending_values.pop_front();
      end else begin
        number_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random ready, forced low during the long stall.
  always @(posedge clk) begin
    if (rst) begin
      text_bus.ready <= 1'b0;
    end else begin
      text_bus.ready <= !receiver_held && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver stall, counted here once armed.
  initial begin
    wait (hold_armed);
    @(posedge clk);
    receiver_held <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_held <= 1'b0;
  end

  // Monitor: predicts on accepted values and checks every digit beat.
  always @(posedge clk) begin
    digit_beat_t want;
    if (!rst) begin
      if (number_bus.valid && number_bus.ready)
        push_decimal_digits(number_bus.value);
      if (text_bus.valid && text_bus.ready) begin
        if (expected_digits.size() == 0) begin
          report_mismatch($sformatf("digit beat 0x%0h with none expected",
                                    text_bus.digit_char));
        end else begin
          want = expected_digits.pop_front();
          if (text_bus.digit_char !== want.digit_char)
            report_mismatch($sformatf("digit_char 0x%0h, expected 0x%0h",
                                      text_bus.digit_char, want.digit_char));
          if (text_bus.last_digit !== want.last_digit)
            report_mismatch($sformatf("last_digit %0b, expected %0b",
                                      text_bus.last_digit, want.last_digit));
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    #1;

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 32;
    recv_idle_pct = 73;

    // Zero, single digits, powers of ten and the top of the range.
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'd9);
    pending_values.push_back(32'd10);
    pending_values.push_back(32'd99);
    pending_values.push_back(32'd100);
    pending_values.push_back(32'd999);
    pending_values.push_back(32'd1000);
    pending_values.push_back(32'd65535);
    pending_values.push_back(32'd99999999);
    pending_values.push_back(32'd999999999);
    pending_values.push_back(32'd1000000000);
    pending_values.push_back(32'd1234567890);
    pending_values.push_back(32'd2147483647);
    pending_values.push_back(32'd2147483648);
    pending_values.push_back(32'd4000000000);
    pending_values.push_back(32'd4294967290);
    pending_values.push_back(32'd4294967294);
    pending_values.push_back(32'd4294967295);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'h5555_5555);
    pending_values.push_back(32'hAAAA_AAAA);
    queue_random(70);
    wait_drained();

    // Sender idles heavily, receiver lightly.
    send_idle_pct = 73;
    recv_idle_pct = 32;
    queue_random(70);
    wait_drained();

    // No idling, with one long receiver stall while values keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(60);
    hold_armed = 1'b1;
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_digits.size() != 0)
      report_mismatch($sformatf("%0d digit beats never arrived",
                                expected_digits.size()));
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
